// ----- hw/rtl/kba_pkg.sv -----
// ----------------------------------------------------------------------------
// kba_pkg: shared types and constants of the k-mer binned accumulator
// Holds the item payloads, result codes, register indexes, the base decoder
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kba_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned SYMBOL_W  = 8;
  localparam int unsigned AMOUNT_W  = 32;
  localparam int unsigned COLUMN_W  = 5;
  localparam int unsigned COL_OUT_W = 4;
  localparam int unsigned SUM_OUT_W = 40;
  localparam int unsigned EXT_W     = 64;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned COLS_W    = 6;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_KMER_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [2:0] KMER_LENGTH_RST  = 3'd3;
  localparam logic [4:0] COLUMN_COUNT_RST = 5'd4;

  // Item modes.
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Key characters.
  localparam logic [SYMBOL_W-1:0] SYM_A = 8'h41;
  localparam logic [SYMBOL_W-1:0] SYM_C = 8'h43;
  localparam logic [SYMBOL_W-1:0] SYM_G = 8'h47;
  localparam logic [SYMBOL_W-1:0] SYM_T = 8'h54;
  localparam logic [SYMBOL_W-1:0] SYM_U = 8'h55;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_BASE   = 2'd1,
    ST_BAD_COLUMN = 2'd2,
    ST_BAD_LENGTH = 2'd3
  } status_e;

  typedef struct packed {
    logic                       mode;
    logic [SYMBOL_W-1:0]        symbol;
    logic                       key_last;
    logic signed [AMOUNT_W-1:0] add_amount;
    logic [COLUMN_W-1:0]        column;
  } in_item_t;

  typedef struct packed {
    status_e                     status;
    logic                        present;
    logic [COL_OUT_W-1:0]        column_out;
    logic signed [SUM_OUT_W-1:0] sum_value;
    logic                        last_result;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic sweep;
    logic accept;
    logic start_read;
    logic add_commit;
    logic err_out;
    logic col_out;
    logic key_clear;
  } kba_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sweep_last;
    logic in_last;
    logic fail;
    logic is_read;
    logic col_last;
    logic out_free;
  } kba_sts_t;

  // Returns {valid, code}: A=0, C=1, G=2, T or U=3.
  function automatic logic [2:0] base_decode(input logic [SYMBOL_W-1:0] sym);
    logic [2:0] res;
    unique case (sym)
      SYM_A:        res = 3'b1_00;
      SYM_C:        res = 3'b1_01;
      SYM_G:        res = 3'b1_10;
      SYM_T, SYM_U: res = 3'b1_11;
      default:      res = 3'b0_00;
    endcase
    return res;
  endfunction

endpackage

// ----- hw/rtl/kba_if.sv -----
// ----------------------------------------------------------------------------
// kba_if: channel interfaces of the k-mer binned accumulator
// Valid/ready channels for key characters, results and register writes.
// ----------------------------------------------------------------------------

// Key character channel.
interface kba_in_if import kba_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface kba_out_if import kba_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Register write channel.
interface kba_cfg_if import kba_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/kmer_binned_accumulator.sv -----
// Sequence: key characters are taken while idle. After the last one, a rejected key is
// reported from the evaluate step, an add passes evaluate and read, then saturating
// write-back, and a read passes evaluate and read, then gives one column per cycle.
// A result held by the receiver stalls the next step; new requests wait until it ends.
// Reset: registers return to kmer_length 3 and column_count 4, then a clearing pass over
// all 4**MAX_KMER * 2**ceil(log2(MAX_COLUMNS)) entries (65536 by default) holds off requests.
// ----------------------------------------------------------------------------
// kmer_binned_accumulator: table of fixed-point sums indexed by a k-mer key
// Folds nucleotide characters into a row index, then adds a Q16.16 amount
// into one column of the row or reports every column of the row.
// ----------------------------------------------------------------------------
module kmer_binned_accumulator import kba_pkg::*; #(
  parameter int unsigned MAX_KMER    = 6,
  parameter int unsigned MAX_COLUMNS = 16,
  parameter int unsigned ACC_WIDTH   = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kba_in_if.sink      item_i,
  kba_out_if.source   result_o,
  kba_cfg_if.sink     cfg_i
);

  kba_cmd_t cmd;
  kba_sts_t sts;

  // Sequencer.
  kba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Key collector, memories and result register.
  kba_datapath #(
    .MAX_KMER    (MAX_KMER),
    .MAX_COLUMNS (MAX_COLUMNS),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (item_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .out_valid_o (result_o.valid),
    .out_data_o  (result_o.data),
    .out_ready_i (result_o.ready)
  );

`ifndef ASSERT_OFF
  // No request is taken while the store is being cleared.
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep |-> !(item_i.valid && item_i.ready))
    else $error("request accepted during clearing pass");

  // At most one source loads the result register.
  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.err_out, cmd.add_commit, cmd.col_out}))
    else $error("result register loaded by more than one source");

  // A result is never loaded over one that has not been taken.
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.err_out || cmd.add_commit || cmd.col_out) |-> sts.out_free)
    else $error("pending result overwritten");

  // The last character of a key is never directly followed by another accepted request.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready && item_i.data.key_last) |=>
      !(item_i.valid && item_i.ready))
    else $error("request accepted right after end of key");
`endif

endmodule

// ----- hw/rtl/kba_datapath.sv -----
// ----------------------------------------------------------------------------
// kba_datapath: key collector, accumulator store and result register
// Builds the row index from key characters, holds the configuration
// registers, the accumulator and present-bit memories, the saturating adder
// and the output register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module kba_datapath import kba_pkg::*; #(
  parameter int unsigned MAX_KMER    = 6,
  parameter int unsigned MAX_COLUMNS = 16,
  parameter int unsigned ACC_WIDTH   = 40
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kba_cmd_t               cmd_i,
  output kba_sts_t               sts_o,
  input  in_item_t               in_data_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   cfg_ready_o,
  output logic                   out_valid_o,
  output out_item_t              out_data_o,
  input  logic                   out_ready_i
);

  localparam int unsigned ROW_W  = 2 * MAX_KMER;
  localparam int unsigned ROWS   = 2 ** ROW_W;
  localparam int unsigned COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned ADDR_W = ROW_W + COL_W;
  localparam int unsigned DEPTH  = 2 ** ADDR_W;
  localparam int unsigned SUM_W  = ACC_WIDTH + 1;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // Configuration registers.
  logic [2:0] kmer_len_q;
  logic [4:0] col_count_q;

  // Key collector.
  logic [ROW_W-1:0]   key_index_q, key_index_d;
  logic [COUNT_W-1:0] key_count_q, key_count_d;
  logic               key_invalid_q, key_invalid_d;
  logic [2:0]         base;

  // Latched item fields.
  logic                       mode_q;
  logic [COLUMN_W-1:0]        column_q;
  logic signed [AMOUNT_W-1:0] amount_q;

  // Memories and their ports.
  logic signed [ACC_WIDTH-1:0] acc_mem [DEPTH];
  logic                        pres_mem [ROWS];
  logic [ADDR_W-1:0]           sweep_q;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        rd_en;
  logic signed [ACC_WIDTH-1:0] acc_rd_q;
  logic                        pres_rd_q;
  logic [ADDR_W-1:0]           wr_addr_q;
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic signed [ACC_WIDTH-1:0] wr_data;
  logic [COLUMN_W-1:0]         col_q;
  logic [COLUMN_W-1:0]         col_next;

  // Arithmetic and decisions.
  logic signed [SUM_W-1:0]     wide_sum;
  logic signed [ACC_WIDTH-1:0] sat_sum;
  logic signed [EXT_W-1:0]     acc_ext;
  logic [COLS_W-1:0]           cols_eff;
  logic                        len_ok;
  logic                        fail;
  status_e                     err_status;
  logic                        col_last;

  // Output register.
  logic      out_valid_q;
  out_item_t out_q;

  // Register writes are taken at any time.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q  <= KMER_LENGTH_RST;
      col_count_q <= COLUMN_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KMER_LENGTH:  kmer_len_q  <= cfg_data_i[2:0];
        CFG_COLUMN_COUNT: col_count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Key collector: shift in the base code, count characters, note bad ones.
  assign base = base_decode(in_data_i.symbol);

  always_comb begin
    key_index_d   = key_index_q;
    key_count_d   = key_count_q;
    key_invalid_d = key_invalid_q;
    if (cmd_i.key_clear) begin
      key_index_d   = '0;
      key_count_d   = '0;
      key_invalid_d = 1'b0;
    end else if (cmd_i.accept) begin
      if (base[2]) begin
        key_index_d = ROW_W'({key_index_q, base[1:0]});
      end else begin
        key_invalid_d = 1'b1;
      end
      if (key_count_q != '1) begin
        key_count_d = key_count_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_index_q   <= '0;
      key_count_q   <= '0;
      key_invalid_q <= 1'b0;
    end else begin
      key_index_q   <= key_index_d;
      key_count_q   <= key_count_d;
      key_invalid_q <= key_invalid_d;
    end
  end

  // Item fields are kept for the final character of the key.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= in_data_i.mode;
      column_q <= in_data_i.column;
      amount_q <= in_data_i.add_amount;
    end
  end

  // Error decision on the finished key.
  always_comb begin
    if ({1'b0, col_count_q} > COLS_W'(MAX_COLUMNS)) begin
      cols_eff = COLS_W'(MAX_COLUMNS);
    end else begin
      cols_eff = {1'b0, col_count_q};
    end
    len_ok = (kmer_len_q != '0) && ({1'b0, kmer_len_q} <= COUNT_W'(MAX_KMER)) &&
             (key_count_q == {1'b0, kmer_len_q});
    fail       = 1'b1;
    err_status = ST_OK;
    if (mode_q == MODE_ADD) begin
      priority if ({1'b0, column_q} >= cols_eff) begin
        err_status = ST_BAD_COLUMN;
      end else if (key_invalid_q) begin
        err_status = ST_OK;
      end else if (!len_ok) begin
        err_status = ST_BAD_LENGTH;
      end else begin
        fail = 1'b0;
      end
    end else begin
      priority if (key_invalid_q) begin
        err_status = ST_BAD_BASE;
      end else if (!len_ok) begin
        err_status = ST_BAD_LENGTH;
      end else if (cols_eff == '0) begin
        err_status = ST_BAD_COLUMN;
      end else begin
        fail = 1'b0;
      end
    end
  end

  // Column stepping for reads.
  assign col_next = col_q + COLUMN_W'(1);
  assign col_last = (COLS_W'({1'b0, col_q}) + COLS_W'(1)) == cols_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (cmd_i.start_read) begin
      col_q <= '0;
    end else if (cmd_i.col_out) begin
      col_q <= col_next;
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_q + ADDR_W'(1);
    end
  end

  // Read port: first column or add target on start, next column on each step.
  always_comb begin
    rd_en   = cmd_i.start_read || cmd_i.col_out;
    rd_addr = {key_index_q, col_next[COL_W-1:0]};
    if (cmd_i.start_read) begin
      if (mode_q == MODE_ADD) begin
        rd_addr = {key_index_q, column_q[COL_W-1:0]};
      end else begin
        rd_addr = {key_index_q, {COL_W{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      acc_rd_q <= acc_mem[rd_addr];
    end
    if (cmd_i.start_read) begin
      pres_rd_q <= pres_mem[rd_addr[ADDR_W-1:COL_W]];
      wr_addr_q <= rd_addr;
    end
  end

  // Saturating add of the Q16.16 amount into the accumulator.
  assign wide_sum = SUM_W'(acc_rd_q) + SUM_W'(amount_q);

  always_comb begin
    if (wide_sum[ACC_WIDTH] != wide_sum[ACC_WIDTH-1]) begin
      sat_sum = wide_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_sum = wide_sum[ACC_WIDTH-1:0];
    end
  end

  // Write port: zeros during the sweep, the new sum on an add.
  assign wr_en   = cmd_i.sweep || cmd_i.add_commit;
  assign wr_addr = cmd_i.sweep ? sweep_q : wr_addr_q;
  assign wr_data = cmd_i.sweep ? '0 : sat_sum;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      acc_mem[wr_addr]               <= wr_data;
      pres_mem[wr_addr[ADDR_W-1:COL_W]] <= !cmd_i.sweep;
    end
  end

  // Output register.
  assign acc_ext = EXT_W'(acc_rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.err_out || cmd_i.add_commit || cmd_i.col_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.err_out) begin
      out_q.status      <= err_status;
      out_q.present     <= 1'b0;
      out_q.column_out  <= '0;
      out_q.sum_value   <= '0;
      out_q.last_result <= 1'b1;
    end else if (cmd_i.add_commit) begin
      out_q.status      <= ST_OK;
      out_q.present     <= 1'b1;
      out_q.column_out  <= column_q[COL_OUT_W-1:0];
      out_q.sum_value   <= '0;
      out_q.last_result <= 1'b1;
    end else if (cmd_i.col_out) begin
      out_q.status      <= ST_OK;
      out_q.present     <= pres_rd_q;
      out_q.column_out  <= col_q[COL_OUT_W-1:0];
      out_q.sum_value   <= acc_ext[SUM_OUT_W-1:0];
      out_q.last_result <= col_last;
    end else begin
      out_q <= out_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller.
  assign sts_o.sweep_last = (sweep_q == '1);
  assign sts_o.in_last    = in_data_i.key_last;
  assign sts_o.fail       = fail;
  assign sts_o.is_read    = (mode_q == MODE_READ);
  assign sts_o.col_last   = col_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ----- hw/rtl/kba_ctrl.sv -----
// ----------------------------------------------------------------------------
// kba_ctrl: sequencer of the k-mer binned accumulator
// Runs the clearing sweep after reset, takes key characters, and steps the
// datapath through an add or a column-by-column read of the finished key.
// ----------------------------------------------------------------------------
module kba_ctrl import kba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  kba_sts_t sts_i,
  output kba_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_ADD_WB,
    S_RD_COL
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      // Zero every accumulator and present bit.
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      // Collect key characters.
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_last) begin
            state_d = S_EVAL;
          end
        end
      end
      // Report an error or start the memory access.
      S_EVAL: begin
        if (sts_i.fail) begin
          if (sts_i.out_free) begin
            cmd_o.err_out   = 1'b1;
            cmd_o.key_clear = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.start_read = 1'b1;
          state_d          = sts_i.is_read ? S_RD_COL : S_ADD_WB;
        end
      end
      // Write back the sum and report the add.
      S_ADD_WB: begin
        if (sts_i.out_free) begin
          cmd_o.add_commit = 1'b1;
          cmd_o.key_clear  = 1'b1;
          state_d          = S_IDLE;
        end
      end
      // Emit one column per cycle while the result register is free.
      S_RD_COL: begin
        if (sts_i.out_free) begin
          cmd_o.col_out = 1'b1;
          if (sts_i.col_last) begin
            cmd_o.key_clear = 1'b1;
            state_d         = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- verif/kba_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kba_table_checker: result predictor and comparator for the k-mer table
// Watches the key character, result and register write channels, keeps its
// own copy of the row index collector, the sums and the present bits, and
// compares every accepted result with the oldest predicted one.
// ----------------------------------------------------------------------------
module kba_table_checker import kba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  kba_in_if    item_mon,
  kba_out_if   result_mon,
  kba_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned KMER_MAX = 6;
  localparam int unsigned COLS_MAX = 16;
  localparam int unsigned ROW_BITS = 2 * KMER_MAX;
  localparam int unsigned REPORT_MAX = 10;
  localparam logic signed [SUM_OUT_W:0] SUM_HI = 41'sh07F_FFFF_FFFF;
  localparam logic signed [SUM_OUT_W:0] SUM_LO = -SUM_HI - 41'sd1;

  // Register copies and key collector.
  logic [2:0]          kmer_len;
  logic [4:0]          col_count;
  logic [ROW_BITS-1:0] key_row;
  logic [COUNT_W-1:0]  key_cnt;
  bit                  key_bad;

  // Sums that were never written read as zero.
  logic signed [SUM_OUT_W-1:0] sums [int];
  bit [(1 << ROW_BITS)-1:0]    row_seen;

  out_item_t expected_results [$];
  int        mismatches;

  // Returns 0..3 for a nucleotide letter and -1 for anything else.
  function automatic int nucleotide_code(input logic [SYMBOL_W-1:0] sym);
    case (sym)
      SYM_A:        return 0;
      SYM_C:        return 1;
      SYM_G:        return 2;
      SYM_T, SYM_U: return 3;
      default:      return -1;
    endcase
  endfunction

  task automatic expect_result(input status_e st, input logic pr,
                               input logic [COL_OUT_W-1:0] col,
                               input logic signed [SUM_OUT_W-1:0] sum,
                               input logic last);
    out_item_t r;
    r.status      = st;
    r.present     = pr;
    r.column_out  = col;
    r.sum_value   = sum;
    r.last_result = last;
    expected_results.push_back(r);
  endtask

  // Folds one key character into the collector and, on the last one, works
  // out the results of the add or the read.
  task automatic predict_key_char(input in_item_t it);
    int                          code;
    int                          ncols;
    int                          slot;
    bit                          len_ok;
    logic signed [SUM_OUT_W-1:0] cur;
    logic signed [SUM_OUT_W:0]   wide;
    code = nucleotide_code(it.symbol);
    if (code < 0) begin
      key_bad = 1'b1;
    end else begin
      key_row = {key_row[ROW_BITS-3:0], code[1:0]};
    end
    if (key_cnt != 4'd15) begin
      key_cnt = key_cnt + 4'd1;
    end
    if (!it.key_last) begin
      return;
    end
    ncols  = (col_count > COLS_MAX) ? COLS_MAX : int'(col_count);
    len_ok = (kmer_len >= 3'd1) && (kmer_len <= 3'(KMER_MAX)) &&
             (key_cnt == {1'b0, kmer_len});
    if (it.mode == MODE_ADD) begin
      // The column is checked first, then the bases, then the length.
      if (int'(it.column) >= ncols) begin
        expect_result(ST_BAD_COLUMN, 1'b0, '0, '0, 1'b1);
      end else if (key_bad) begin
        expect_result(ST_OK, 1'b0, '0, '0, 1'b1);
      end else if (!len_ok) begin
        expect_result(ST_BAD_LENGTH, 1'b0, '0, '0, 1'b1);
      end else begin
        slot = int'(key_row) * COLS_MAX + int'(it.column);
        cur  = sums.exists(slot) ? sums[slot] : '0;
        wide = $signed({cur[SUM_OUT_W-1], cur}) +
               $signed({{(SUM_OUT_W + 1 - AMOUNT_W){it.add_amount[AMOUNT_W-1]}},
                        it.add_amount});
        if (wide > SUM_HI) begin
          wide = SUM_HI;
        end else if (wide < SUM_LO) begin
          wide = SUM_LO;
        end
        sums[slot]        = wide[SUM_OUT_W-1:0];
        row_seen[key_row] = 1'b1;
        expect_result(ST_OK, 1'b1, it.column[COL_OUT_W-1:0], '0, 1'b1);
      end
    end else begin
      if (key_bad) begin
        expect_result(ST_BAD_BASE, 1'b0, '0, '0, 1'b1);
      end else if (!len_ok) begin
        expect_result(ST_BAD_LENGTH, 1'b0, '0, '0, 1'b1);
      end else if (ncols == 0) begin
        expect_result(ST_BAD_COLUMN, 1'b0, '0, '0, 1'b1);
      end else begin
        for (int c = 0; c < ncols; c++) begin
          slot = int'(key_row) * COLS_MAX + c;
          cur  = sums.exists(slot) ? sums[slot] : '0;
          expect_result(ST_OK, row_seen[key_row], 4'(c), cur, c == ncols - 1);
        end
      end
    end
    key_row = '0;
    key_cnt = '0;
    key_bad = 1'b0;
  endtask

  // Compares one result with the oldest prediction.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: result with none predicted: status %0d column %0d sum %0d",
                 $realtime, got.status, got.column_out, got.sum_value);
      end
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status || got.present !== want.present ||
        got.column_out !== want.column_out || got.sum_value !== want.sum_value ||
        got.last_result !== want.last_result) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: result mismatch, expected st %0d pr %0b col %0d sum %0d last %0b",
                 $realtime, want.status, want.present, want.column_out,
                 want.sum_value, want.last_result);
        $display("%0t:                  actual   st %0d pr %0b col %0d sum %0d last %0b",
                 $realtime, got.status, got.present, got.column_out,
                 got.sum_value, got.last_result);
      end
    end
  endtask

  // Register writes, key characters and results are all taken at the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len  = KMER_LENGTH_RST;
      col_count = COLUMN_COUNT_RST;
      key_row   = '0;
      key_cnt   = '0;
      key_bad   = 1'b0;
      row_seen  = '0;
      sums.delete();
      expected_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_KMER_LENGTH:  kmer_len = cfg_mon.data[2:0];
          CFG_COLUMN_COUNT: col_count = cfg_mon.data[4:0];
          default: ;
        endcase
      end
      if (item_mon.valid && item_mon.ready) begin
        predict_key_char(item_mon.data);
      end
      if (result_mon.valid && result_mon.ready) begin
        check_result(result_mon.data);
      end
    end
    pending_o    = expected_results.size();
    fail_count_o = mismatches;
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level test of the k-mer binned accumulator
// Resets the block, runs a directed set of keys, a run of large adds and a
// series of random phases under several register settings, with bursty
// requests, a stalling result receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import kba_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned KMER_MAX     = 6;
  localparam int unsigned ROW_W        = 2 * KMER_MAX;
  localparam int unsigned HOT_ROWS     = 6;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  kba_in_if  item_ch ();
  kba_out_if result_ch ();
  kba_cfg_if cfg_ch ();

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  bit          hold_go = 1'b0;
  int          burst_left = 0;
  int          chars_sent = 0;
  int          cur_k;
  int          cur_cols;

  logic [SYMBOL_W-1:0] key_chars [$];
  logic [ROW_W-1:0]    hot_rows [HOT_ROWS];

  always #1 clk_i = ~clk_i;

  kmer_binned_accumulator uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  kba_table_checker table_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mon     (item_ch),
    .result_mon   (result_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[kmer_binned_accumulator] ERROR");
      $finish;
    end
  end

  // Result receiver: segments of steady, light and heavy stalling, and one
  // long hold-off once the top asks for it.
  initial begin
    int seg_len;
    int seg_kind;
    bit hold_done;
    hold_done = 1'b0;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      seg_len  = $urandom_range(4, 40);
      seg_kind = $urandom_range(0, 3);
      repeat (seg_len) begin
        case (seg_kind)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= 1'($urandom_range(0, 1));
          2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
          default: result_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [SYMBOL_W-1:0] base_letter(input logic [1:0] code);
    case (code)
      2'd0:    return SYM_A;
      2'd1:    return SYM_C;
      2'd2:    return SYM_G;
      default: return ($urandom_range(0, 1) != 0) ? SYM_T : SYM_U;
    endcase
  endfunction

  function automatic logic [SYMBOL_W-1:0] non_base();
    logic [SYMBOL_W-1:0] s;
    do begin
      s = 8'($urandom_range(0, 255));
    end while (s inside {SYM_A, SYM_C, SYM_G, SYM_T, SYM_U});
    return s;
  endfunction

  // Offers one key character request, with bursts and random gaps.
  task automatic send_char(input logic mode, input logic [SYMBOL_W-1:0] sym,
                           input logic last, input logic [AMOUNT_W-1:0] amt,
                           input logic [COLUMN_W-1:0] col);
    in_item_t it;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    it.mode       = mode;
    it.symbol     = sym;
    it.key_last   = last;
    it.add_amount = amt;
    it.column     = col;
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk_i); while (!item_ch.ready);
    chars_sent++;
  endtask

  // Sends the collected key; fields other than the symbol are random on
  // every character but the last.
  task automatic send_key(input logic mode, input logic [AMOUNT_W-1:0] amt,
                          input logic [COLUMN_W-1:0] col);
    foreach (key_chars[i]) begin
      if (i == key_chars.size() - 1) begin
        send_char(mode, key_chars[i], 1'b1, amt, col);
      end else begin
        send_char(1'($urandom_range(0, 1)), key_chars[i], 1'b0, $urandom(),
                  5'($urandom_range(0, 31)));
      end
    end
  endtask

  task automatic set_key(input string s);
    key_chars.delete();
    for (int i = 0; i < s.len(); i++) begin
      key_chars.push_back(s[i]);
    end
  endtask

  // Spells a row index as a key of the given length, oldest base first.
  task automatic load_row_key(input logic [ROW_W-1:0] row, input int len);
    key_chars.delete();
    for (int i = len - 1; i >= 0; i--) begin
      key_chars.push_back(base_letter(2'((row >> (2 * i)) & 3)));
    end
  endtask

  // Drops valid, waits for every predicted result and lets the block settle.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes both registers back to back.
  task automatic write_config(input int k, input int cols);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_KMER_LENGTH;
    cfg_ch.data  <= 8'(k);
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_COLUMN_COUNT;
    cfg_ch.data  <= 8'(cols);
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_k    = k;
    cur_cols = (cols > 16) ? 16 : cols;
  endtask

  // One random key: mostly well-formed keys on a few busy rows, the rest
  // wrong lengths, bad bases and plain noise.
  task automatic random_key();
    int                  kind;
    int                  len;
    int                  col_hi;
    logic                mode;
    logic [COLUMN_W-1:0] col;
    logic [AMOUNT_W-1:0] amt;
    kind   = $urandom_range(0, 9);
    mode   = ($urandom_range(0, 9) < 4) ? MODE_READ : MODE_ADD;
    col_hi = (cur_cols == 0) ? 31 : cur_cols - 1;
    col    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, col_hi));
    case ($urandom_range(0, 3))
      0:       amt = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1:       amt = 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
      default: amt = $urandom();
    endcase
    len = (cur_k >= 1 && cur_k <= KMER_MAX) ? cur_k : $urandom_range(1, 8);
    if (kind == 8) begin
      do len = $urandom_range(1, 17); while (len == cur_k);
    end
    load_row_key(hot_rows[$urandom_range(0, HOT_ROWS - 1)], len);
    if (kind == 9) begin
      key_chars[$urandom_range(0, len - 1)] = non_base();
    end else if (kind == 7) begin
      foreach (key_chars[i]) key_chars[i] = 8'($urandom_range(0, 255));
    end
    send_key(mode, amt, col);
  endtask

  // A random phase under one register setting.
  task automatic run_phase(input int k, input int cols, input int n_chars,
                           input bit with_hold);
    int first;
    int row_hi;
    wait_idle();
    write_config(k, cols);
    if (with_hold) begin
      hold_go <= 1'b1;
    end
    row_hi = (k >= 1 && k <= KMER_MAX) ? (1 << (2 * k)) - 1 : (1 << ROW_W) - 1;
    foreach (hot_rows[i]) hot_rows[i] = ROW_W'($urandom_range(0, row_hi));
    first = chars_sent;
    while (chars_sent - first < n_chars) random_key();
  endtask

  // Stimulus and verdict.
  initial begin
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed keys at the reset setting of three bases and four columns.
    cur_k    = KMER_LENGTH_RST;
    cur_cols = COLUMN_COUNT_RST;
    set_key("ACG");
    send_key(MODE_READ, $urandom(), 5'd0);
    set_key("TGU");
    send_key(MODE_ADD, 32'h7FFF_FFFF, 5'd3);
    // T and U fold to the same row.
    set_key("TGT");
    send_key(MODE_ADD, 32'h8000_0000, 5'd3);
    set_key("UGT");
    send_key(MODE_READ, 32'h0, 5'd0);
    // A column at the count is flagged even with a bad base in the key.
    set_key("AAA");
    key_chars[1] = 8'hFF;
    send_key(MODE_ADD, 32'h0001_0000, 5'd4);
    // A bad base alone turns an add into a silent no-op.
    set_key("CCC");
    key_chars[2] = 8'h00;
    send_key(MODE_ADD, 32'h0001_0000, 5'd0);
    // On a read a bad base wins over a short key.
    set_key("Gq");
    send_key(MODE_READ, 32'h0, 5'd0);
    set_key("ACGT");
    send_key(MODE_ADD, 32'h0002_0000, 5'd1);

    // Large sums: push one sum well past 32 bits, then far below zero.
    wait_idle();
    write_config(1, 1);
    repeat (8) send_char(MODE_ADD, SYM_G, 1'b1, 32'h7FFF_FFFF, 5'd0);
    send_char(MODE_READ, SYM_G, 1'b1, $urandom(), 5'($urandom_range(0, 31)));
    repeat (16) send_char(MODE_ADD, SYM_G, 1'b1, 32'h8000_0000, 5'd0);
    send_char(MODE_READ, SYM_G, 1'b1, $urandom(), 5'($urandom_range(0, 31)));
    send_char(MODE_READ, SYM_A, 1'b1, $urandom(), 5'($urandom_range(0, 31)));

    // Random phases, out-of-range register values among them.
    run_phase(6, 16, 48, 1'b0);
    run_phase(2, 7, 30, 1'b0);
    run_phase(0, 0, 12, 1'b0);
    run_phase(7, 31, 12, 1'b0);
    run_phase(1, 20, 16, 1'b0);
    run_phase(4, 16, 80, 1'b1);

    wait_idle();
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[kmer_binned_accumulator] OK");
    end else begin
      $display("[kmer_binned_accumulator] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/kba_pkg.sv
hw/rtl/kba_if.sv
hw/rtl/kba_datapath.sv
hw/rtl/kba_ctrl.sv
hw/rtl/kmer_binned_accumulator.sv
verif/kba_table_checker.sv
verif/tb.sv
